// ===== rtl/smt_pkg.sv =====
// Shared types and constants for the sorted mutation table.
`timescale 1ns / 1ps
package smt_pkg;

  localparam int POS_W   = 31;
  localparam int BASE_W  = 4;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 3;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_CONFLICT = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd5;
  localparam logic [STAT_W-1:0] ST_READ_OK  = 3'd6;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd7;

  typedef struct packed {
    logic [1:0]        kind;
    logic [POS_W-1:0]  position;
    logic [BASE_W-1:0] parent_base;
    logic [BASE_W-1:0] mutant_base;
    logic [SLOT_W-1:0] slot;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
    logic [POS_W-1:0]   read_position;
    logic [BASE_W-1:0]  read_parent;
    logic [BASE_W-1:0]  read_mutant;
  } out_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [BASE_W-1:0] par;
    logic [BASE_W-1:0] mut;
  } rec_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_UPDATE,
    OP_REMOVE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic              load;
    logic              lookup;
    logic              apply;
    op_t               op;
    logic [STAT_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       hit;
    logic       par_differs;
    logic       mut_differs;
    logic       full;
    logic       rd_hit;
  } sts_t;

endpackage

// ===== rtl/smt_ctrl.sv =====
// Sequencer for the mutation table: accept, lookup, apply, and response handshake.
`timescale 1ns / 1ps
module smt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  smt_pkg::sts_t sts,
  output smt_pkg::cmd_t cmd
);
  import smt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_APPLY
  } state_t;

  state_t state;
  logic   out_free;
  op_t    op;
  logic [STAT_W-1:0] code;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    op   = OP_NONE;
    code = ST_EMPTY;
    unique case (sts.kind)
      KIND_ADD: begin
        if (sts.hit) begin
          if (sts.par_differs) begin
            op   = OP_UPDATE;
            code = ST_UPDATED;
          end else if (sts.mut_differs) begin
            code = ST_CONFLICT;
          end else begin
            op   = OP_REMOVE;
            code = ST_REMOVED;
          end
        end else if (sts.full) begin
          code = ST_FULL;
        end else begin
          op   = OP_INSERT;
          code = ST_INSERTED;
        end
      end
      KIND_CLEAR: begin
        op   = OP_CLEAR;
        code = ST_CLEARED;
      end
      KIND_READ: begin
        code = sts.rd_hit ? ST_READ_OK : ST_EMPTY;
      end
      default: begin
        code = ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = req_valid && req_ready;
    cmd.lookup = (state == S_LOOKUP);
    cmd.apply  = (state == S_APPLY) && out_free;
    cmd.op     = op;
    cmd.code   = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.apply) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/smt_cells.sv =====
// Datapath: chain of record cells with per-cell compare, shift and read-out logic.
`timescale 1ns / 1ps
module smt_cells #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  smt_pkg::in_t  req,
  input  smt_pkg::cmd_t cmd,
  output smt_pkg::sts_t sts,
  output smt_pkg::out_t rsp
);
  import smt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;

  in_t  item;
  rec_t cells [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] rd;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CAPACITY-1:0] par_diff;
  logic [CAPACITY-1:0] mut_diff;
  rec_t rd_rec;
  rec_t new_rec;

  assign new_rec = '{pos: item.position, par: item.parent_base, mut: item.mutant_base};

  always_ff @(posedge clk) begin
    if (cmd.load) item <= req;
  end

  // Flags: lt marks live cells below the key, eq the matching cell, rd the read slot.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      for (int k = 0; k < CAPACITY; k++) begin
        lt[k] <= (CW'(k) < count) && (cells[k].pos < item.position);
        eq[k] <= (CW'(k) < count) && (cells[k].pos == item.position);
        rd[k] <= (CW'(k) < count) && (SW'(item.slot) == SW'(k));
      end
    end
  end

  always_comb begin
    rd_rec = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      par_diff[k] = eq[k] && (cells[k].par != item.mutant_base);
      mut_diff[k] = eq[k] && (cells[k].mut != item.parent_base);
      rd_rec      = rd_rec | (cells[k] & {$bits(rec_t){rd[k]}});
    end
  end

  assign sts.kind        = item.kind;
  assign sts.hit         = |eq;
  assign sts.par_differs = |par_diff;
  assign sts.mut_differs = |mut_diff;
  assign sts.full        = (count == CW'(CAPACITY));
  assign sts.rd_hit      = |rd;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    rec_t below;
    rec_t above;
    if (g == 0) begin : g_first
      assign below = new_rec;
    end else begin : g_mid
      // First cell at or above the key takes the new record, later cells shift up.
      assign below = lt[g-1] ? new_rec : cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign above = cells[g];
    end else begin : g_inner
      assign above = cells[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        unique case (cmd.op)
          OP_INSERT: begin
            if (!lt[g]) cells[g] <= below;
          end
          OP_REMOVE: begin
            if (!lt[g]) cells[g] <= above;
          end
          OP_UPDATE: begin
            if (eq[g]) cells[g].mut <= item.mutant_base;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (cmd.op)
      OP_INSERT: count_next = count + CW'(1);
      OP_REMOVE: count_next = count - CW'(1);
      OP_CLEAR:  count_next = '0;
      default:   count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rsp.status      <= cmd.code;
      rsp.entry_count <= COUNT_W'(count_next);
      if (cmd.code == ST_READ_OK) begin
        rsp.read_position <= rd_rec.pos;
        rsp.read_parent   <= rd_rec.par;
        rsp.read_mutant   <= rd_rec.mut;
      end else begin
        rsp.read_position <= '0;
        rsp.read_parent   <= '0;
        rsp.read_mutant   <= '0;
      end
    end
  end

endmodule

// ===== rtl/sorted_mutation_table.sv =====
// Top level of the sorted mutation table.
`timescale 1ns / 1ps
// Holds up to CAPACITY mutation records in a chain of cells kept sorted by
// position. An add inserts, updates or removes a record; clear empties the
// table; read returns the record at a slot. Every request gives exactly one
// response. A request passes three steps: the transfer into the input register,
// a lookup step in which every cell compares its position with the key, and an
// apply step in which the cells shift or update and the response register loads.
// The next request is taken in the cycle after that, so a new request is taken
// only once the last one is through. The apply step waits only while a
// finished response is still waiting to be taken. Table contents need no
// clearing after reset: only slots below the record count are ever read.
module sorted_mutation_table #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  smt_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output smt_pkg::out_t rsp
);
  import smt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  smt_cells #(
    .CAPACITY (CAPACITY)
  ) u_cells (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// ===== rtl/smt_checker.sv =====
// Port-level checks for the sorted mutation table, bound to the top level.
`timescale 1ns / 1ps
module smt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input smt_pkg::out_t rsp
);
  import smt_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // One request in flight: after a transfer the input is closed in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_CLEARED) |-> (rsp.entry_count == '0))
    else $error("clear left records behind");

  a_read_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_READ_OK) |->
      (rsp.read_position == '0) && (rsp.read_parent == '0) && (rsp.read_mutant == '0))
    else $error("read fields set on a non-read response");

endmodule

bind sorted_mutation_table smt_checker u_smt_checker (.*);
